@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int IDX_W     = 11;
   localparam int LINK_W    = 12;
   localparam int LINK_DEPTH = 2048;
   localparam int STEP_W    = 12;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;

   localparam mode_type MODE_INIT = 2'd0;
   localparam mode_type MODE_TAKE = 2'd1;
   localparam mode_type MODE_GIVE = 2'd2;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NO_FREE = 2'd1;
   localparam status_type ST_TOO_BIG = 2'd2;

   localparam logic [LINK_W-1:0] NIL = 12'h800;

endpackage

@@ sv/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a pool of blocks, one LIFO free list per order.
// ----------------------------------------------------------------------------
// Usage:
//   csr_ writes set pool_blocks; write only while idle.
//   req_ channel carries mode, request_bytes, block_index; rsp_ returns
//   granted_index and status, one word per request.
//   One request at a time: req_ready is high only while the sequencer idles.
//   A give does up to (ORDERS-1) list walks, each link visited in S_GCHK
//   and then S_GRD; the link RAM read (one port, registered) sets the walk
//   rate.
//   Reset empties all free lists and clears pool_blocks. The link RAM is not
//   cleared; a chunk's link is written when the chunk is pushed.
//   The result sits in an output register; while rsp_ready is low the block
//   holds it and accepts no new request.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
   parameter int ORDERS      = 11,
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [10:0]          csr_pool_blocks,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [23:0]          req_request_bytes,
   input  logic [10:0]          req_block_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [10:0]          rsp_granted_index,
   output logic [1:0]           rsp_status
);
   import bba_pkg::*;

   localparam int OW = $clog2(ORDERS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_TSCAN = 4'd2;
   localparam logic [3:0] S_TPOP  = 4'd3;
   localparam logic [3:0] S_TSPL  = 4'd4;
   localparam logic [3:0] S_GBUD  = 4'd5;
   localparam logic [3:0] S_GRD   = 4'd6;
   localparam logic [3:0] S_GCHK  = 4'd7;
   localparam logic [3:0] S_GUNL  = 4'd8;
   localparam logic [3:0] S_GPUSH = 4'd9;
   localparam logic [3:0] S_RESP  = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [10:0]       pool_ff;
   logic [LINK_W-1:0] heads_ff [ORDERS];
   logic [OW-1:0]     k_ff, k_in, want_ff, want_in;
   logic [IDX_W-1:0]  idx_ff, idx_in, partner_ff, partner_in;
   logic [LINK_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [11:0]       ipos_ff, ipos_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   status_type        rsp_st_ff, rsp_st_in;

   // head update: one per cycle
   logic              hw_en;
   logic [OW-1:0]     hw_k;
   logic [LINK_W-1:0] hw_val;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_addr;
   logic [LINK_W-1:0] ram_wd, ram_rd;

   logic [5:0]        ord;
   logic [IDX_W:0]    size_w;

   bba_order #(.BLOCK_BYTES(BLOCK_BYTES)) u_order (
      .bytes (req_request_bytes),
      .order (ord)
   );

   bba_ram #(.WIDTH(LINK_W), .DEPTH(LINK_DEPTH)) u_links (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_granted_index = rsp_idx_ff;
   assign rsp_status        = rsp_st_ff;
   assign size_w            = (IDX_W + 1)'(1) << k_ff;

   always_comb begin
      logic [IDX_W+1:0] bud;
      state_in   = state_ff;
      k_in       = k_ff;
      want_in    = want_ff;
      idx_in     = idx_ff;
      partner_in = partner_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      steps_in   = steps_ff;
      ipos_in    = ipos_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_st_in  = rsp_st_ff;
      hw_en      = 1'b0;
      hw_k       = k_ff;
      hw_val     = NIL;
      ram_we     = 1'b0;
      ram_addr   = idx_ff;
      ram_wd     = NIL;
      bud        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               idx_in     = req_block_index;
               rsp_idx_in = '0;
               rsp_st_in  = ST_OK;
               ipos_in    = '0;
               want_in    = OW'(ord);
               k_in       = OW'(ord);
               if (req_mode == MODE_INIT) begin
                  k_in     = OW'(ORDERS - 1);
                  state_in = S_INIT;
               end else if (req_mode == MODE_TAKE || req_mode == MODE_GIVE) begin
                  if (ord >= 6'(ORDERS)) begin
                     rsp_st_in = ST_TOO_BIG;
                     state_in  = S_RESP;
                  end else if (req_mode == MODE_TAKE) begin
                     state_in = S_TSCAN;
                  end else begin
                     state_in = S_GBUD;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         // walk orders top down; every list was emptied when the request was accepted
         S_INIT: begin
            if (pool_ff[k_ff]) begin
               ram_we   = 1'b1;
               ram_addr = ipos_ff[IDX_W-1:0];
               ram_wd   = NIL;
               hw_en    = 1'b1;
               hw_val   = {1'b0, ipos_ff[IDX_W-1:0]};
               ipos_in  = ipos_ff + 12'(size_w);
            end
            if (k_ff == '0) begin
               state_in = S_RESP;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         S_TSCAN: begin
            if (!heads_ff[k_ff][IDX_W]) begin
               idx_in   = heads_ff[k_ff][IDX_W-1:0];
               ram_addr = heads_ff[k_ff][IDX_W-1:0];
               state_in = S_TPOP;
            end else if (k_ff == OW'(ORDERS - 1)) begin
               rsp_st_in = ST_NO_FREE;
               state_in  = S_RESP;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_TPOP: begin
            hw_en    = 1'b1;
            hw_val   = ram_rd;
            state_in = S_TSPL;
         end
         S_TSPL: begin
            if (k_ff == want_ff) begin
               rsp_idx_in = idx_ff;
               state_in   = S_RESP;
            end else begin
               bud      = (IDX_W + 2)'(idx_ff) + (IDX_W + 2)'(size_w >> 1);
               hw_k     = k_ff - 1'b1;
               hw_en    = 1'b1;
               hw_val   = {1'b0, bud[IDX_W-1:0]};
               ram_we   = 1'b1;
               ram_addr = bud[IDX_W-1:0];
               ram_wd   = heads_ff[k_ff - 1'b1];
               k_in     = k_ff - 1'b1;
            end
         end
         S_GBUD: begin
            if (k_ff == OW'(ORDERS - 1)) begin
               state_in = S_GPUSH;
            end else if ((idx_ff & (size_w[IDX_W-1:0] | (size_w[IDX_W-1:0] - 1'b1)))
                         == '0) begin
               // aligned to 2^(k+1): buddy above
               bud = (IDX_W + 2)'(idx_ff) + (IDX_W + 2)'(size_w);
               if (bud > (IDX_W + 2)'(LINK_DEPTH - 1)) begin
                  state_in = S_GPUSH;
               end else begin
                  partner_in = bud[IDX_W-1:0];
                  cur_in     = heads_ff[k_ff];
                  prev_in    = NIL;
                  steps_in   = '0;
                  state_in   = S_GCHK;
               end
            end else if (idx_ff < size_w[IDX_W-1:0]) begin
               // buddy below block 0: none
               state_in = S_GPUSH;
            end else begin
               partner_in = idx_ff - size_w[IDX_W-1:0];
               cur_in     = heads_ff[k_ff];
               prev_in    = NIL;
               steps_in   = '0;
               state_in   = S_GCHK;
            end
         end
         S_GCHK: begin
            ram_addr = cur_ff[IDX_W-1:0];
            if (cur_ff[IDX_W]) begin
               state_in = S_GPUSH;
            end else if (cur_ff[IDX_W-1:0] == partner_ff) begin
               ram_addr = partner_ff;
               state_in = S_GUNL;
            end else if (steps_ff == 12'(LINK_DEPTH)) begin
               state_in = S_GPUSH;
            end else begin
               state_in = S_GRD;
            end
         end
         S_GRD: begin
            prev_in  = cur_ff;
            cur_in   = ram_rd;
            steps_in = steps_ff + 1'b1;
            state_in = S_GCHK;
         end
         S_GUNL: begin
            if (prev_ff[IDX_W]) begin
               hw_en  = 1'b1;
               hw_val = ram_rd;
            end else begin
               ram_we   = 1'b1;
               ram_addr = prev_ff[IDX_W-1:0];
               ram_wd   = ram_rd;
            end
            if (partner_ff < idx_ff) begin
               idx_in = partner_ff;
            end
            k_in     = k_ff + 1'b1;
            state_in = S_GBUD;
         end
         S_GPUSH: begin
            ram_we   = 1'b1;
            ram_addr = idx_ff;
            ram_wd   = heads_ff[k_ff];
            hw_en    = 1'b1;
            hw_val   = {1'b0, idx_ff};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pool_ff  <= '0;
         for (int i = 0; i < ORDERS; i++) begin
            heads_ff[i] <= NIL;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            pool_ff <= csr_pool_blocks;
         end
         // init: clear every list on entry, then load
         if (state_ff == S_IDLE && req_valid && req_mode == MODE_INIT) begin
            for (int i = 0; i < ORDERS; i++) begin
               heads_ff[i] <= NIL;
            end
         end else if (hw_en) begin
            heads_ff[hw_k] <= hw_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      want_ff    <= want_in;
      idx_ff     <= idx_in;
      partner_ff <= partner_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      steps_ff   <= steps_in;
      ipos_ff    <= ipos_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_st_ff  <= rsp_st_in;
   end

   a_resp_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted_index == '0)
      else $error("granted index nonzero on failure");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while holding a result");

   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped under stall");

endmodule

@@ sv/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

@@ sv/bba_order.sv @@
// ----------------------------------------------------------------------------
// bba_order
// Byte count to block order: ceil to blocks, then smallest covering power of 2.
// ----------------------------------------------------------------------------
module bba_order #(
   parameter int BLOCK_BYTES = 4096
) (
   input  logic [23:0] bytes,
   output logic [5:0]  order
);

   localparam int SH = $clog2(BLOCK_BYTES);

   logic [23:0] blocks;
   logic [23:0] m1;

   always_comb begin
      blocks = (bytes >> SH) + 24'((bytes & 24'(BLOCK_BYTES - 1)) != 24'd0);
      m1 = blocks - 24'd1;
      order = 6'd0;
      if (blocks > 24'd1) begin
         for (int i = 0; i < 24; i++) begin
            if (m1[i]) begin
               order = 6'(i + 1);
            end
         end
      end
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buddy block allocator. A queue of requests feeds
// a valid/ready driver; each accepted word runs through a shadow free-list
// model and the response words are compared in order against it.
// ----------------------------------------------------------------------------
module tb;
   import bba_pkg::*;

   localparam int ORDERS      = 11;
   localparam int BLOCK_BYTES = 4096;
   localparam int WATCHDOG    = 250000;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_ITEMS = 225;
   localparam mode_type MODE_NONE = 2'd3;

   typedef struct {
      mode_type    mode;
      logic [23:0] bytes;
      logic [10:0] blk;
   } alloc_req_type;

   typedef struct {
      logic [10:0] index;
      status_type  status;
   } alloc_rsp_type;

   typedef struct {
      logic [10:0] index;
      int          order;
   } chunk_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [10:0] csr_pool_blocks = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [23:0] req_request_bytes = '0;
   logic [10:0] req_block_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [10:0] rsp_granted_index;
   logic [1:0]  rsp_status;

   buddy_block_allocator #(.ORDERS(ORDERS), .BLOCK_BYTES(BLOCK_BYTES)) DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_pool_blocks(csr_pool_blocks),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_request_bytes(req_request_bytes), .req_block_index(req_block_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_granted_index(rsp_granted_index), .rsp_status(rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow allocator state
   logic [10:0]       shadow_pool;
   logic [LINK_W-1:0] shadow_heads[ORDERS];
   logic [LINK_W-1:0] shadow_links[LINK_DEPTH];

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   chunk_type     held_chunks[$];
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         idle_cycles = 0;
   bit         failed = 1'b0;
   bit         req_fired = 1'b0;

   function automatic int order_of(logic [23:0] bytes);
      int blocks;
      int k;
      blocks = bytes / BLOCK_BYTES;
      k = 0;
      if (bytes % BLOCK_BYTES != 0) blocks++;
      while (k < 31 && (1 << k) < blocks) k++;
      return k;
   endfunction

   function automatic void push_free(int order, logic [10:0] idx);
      shadow_links[idx] = shadow_heads[order];
      shadow_heads[order] = {1'b0, idx};
   endfunction

   function automatic alloc_rsp_type predict_alloc(alloc_req_type r);
      alloc_rsp_type res;
      int k, i, want, steps;
      logic [10:0] idx;
      logic [LINK_W-1:0] cur, prev;
      int partner, size;
      res.index = '0;
      res.status = ST_OK;
      case (r.mode)
         MODE_INIT: begin
            idx = '0;
            for (k = 0; k < ORDERS; k++) shadow_heads[k] = NIL;
            for (k = 10; k >= 0; k--) begin
               if (shadow_pool[k] && k < ORDERS) begin
                  push_free(k, idx);
                  idx = idx + (11'd1 << k);
               end
            end
         end
         MODE_TAKE: begin
            want = order_of(r.bytes);
            if (want >= ORDERS) begin
               res.status = ST_TOO_BIG;
            end else begin
               for (i = want; i < ORDERS; i++)
                  if (!shadow_heads[i][11]) break;
               if (i >= ORDERS) begin
                  res.status = ST_NO_FREE;
               end else begin
                  idx = shadow_heads[i][10:0];
                  shadow_heads[i] = shadow_links[idx];
                  while (i > want) begin
                     i--;
                     push_free(i, idx + (11'd1 << i));
                  end
                  res.index = idx;
               end
            end
         end
         MODE_GIVE: begin
            k = order_of(r.bytes);
            idx = r.blk;
            if (k >= ORDERS) begin
               res.status = ST_TOO_BIG;
            end else begin
               while (k + 1 < ORDERS) begin
                  size = 1 << k;
                  if (int'(idx) % (size * 2) == 0) begin
                     partner = idx + size;
                  end else begin
                     if (idx < size) break;
                     partner = idx - size;
                  end
                  if (partner > 2047) break;
                  cur = shadow_heads[k];
                  prev = NIL;
                  steps = 0;
                  while (!cur[11] && cur[10:0] != partner && steps < LINK_DEPTH) begin
                     prev = cur;
                     cur = shadow_links[cur[10:0]];
                     steps++;
                  end
                  if (cur[11] || cur[10:0] != partner) break;
                  if (prev[11]) shadow_heads[k] = shadow_links[partner];
                  else shadow_links[prev[10:0]] = shadow_links[partner];
                  if (partner < idx) idx = partner;
                  k++;
               end
               push_free(k, idx);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // sample handshakes, predict, check
   always @(posedge clock) begin
      alloc_req_type r;
      alloc_rsp_type e;
      chunk_type c;
      bit any_fire;
      bit fired;
      any_fire = 1'b0;
      fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            any_fire = 1'b1;
            if (expected_rsps.size() == 0) begin
               $error("response word with none expected: index %0d status %0d",
                      rsp_granted_index, rsp_status);
               failed = 1'b1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_granted_index !== e.index) begin
                  $error("granted_index: expected %0d, got %0d", e.index, rsp_granted_index);
                  failed = 1'b1;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && req_ready) begin
            any_fire = 1'b1;
            fired = 1'b1;
            r.mode = req_mode;
            r.bytes = req_request_bytes;
            r.blk = req_block_index;
            e = predict_alloc(r);
            expected_rsps.push_back(e);
            if (r.mode == MODE_INIT) held_chunks.delete();
            if (r.mode == MODE_TAKE && e.status == ST_OK) begin
               c.index = e.index;
               c.order = order_of(r.bytes);
               held_chunks.push_back(c);
            end
         end
         if (any_fire) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("[buddy_block_allocator] ERROR");
            $finish;
         end
      end
      req_fired <= fired;
   end

   // request driver
   always @(negedge clock) begin
      alloc_req_type r;
      bit busy;
      busy = req_valid && !req_fired;
      if (!busy && !reset && pending_reqs.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
         r = pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_mode <= r.mode;
         req_request_bytes <= r.bytes;
         req_block_index <= r.blk;
      end else if (!busy) begin
         req_valid <= 1'b0;
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [23:0] bytes_for_order(int k);
      if (k == 0) return 24'($urandom_range(BLOCK_BYTES));
      return 24'($urandom_range((1 << k) * BLOCK_BYTES, (1 << (k - 1)) * BLOCK_BYTES + 1));
   endfunction

   task automatic queue_req(mode_type m, logic [23:0] b, logic [10:0] blk);
      alloc_req_type r;
      r.mode = m;
      r.bytes = b;
      r.blk = blk;
      while (pending_reqs.size() > 3) @(negedge clock);
      pending_reqs.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_pool(logic [10:0] value);
      csr_we <= 1'b1;
      csr_pool_blocks <= value;
      shadow_pool = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_word();
      int sel, k, pick;
      chunk_type c;
      sel = $urandom_range(99);
      if (sel < 2) begin
         queue_req(MODE_INIT, 24'($urandom), 11'($urandom));
      end else if (sel < 50) begin
         k = ($urandom_range(9) == 0) ? $urandom_range(11) : $urandom_range(4);
         if ($urandom_range(30) == 0) queue_req(MODE_TAKE, 24'($urandom), 11'($urandom));
         else queue_req(MODE_TAKE, k > 10 ? 24'hFFFFFF : bytes_for_order(k), 11'($urandom));
      end else if (sel < 93 && held_chunks.size() != 0) begin
         pick = $urandom_range(held_chunks.size() - 1);
         c = held_chunks[pick];
         held_chunks.delete(pick);
         queue_req(MODE_GIVE, bytes_for_order(c.order), c.index);
      end else if (sel < 97) begin
         queue_req(MODE_GIVE, ($urandom_range(1) == 0) ? 24'($urandom) :
                   bytes_for_order($urandom_range(3)), 11'($urandom));
      end else begin
         queue_req(MODE_NONE, 24'($urandom), 11'($urandom));
      end
   endtask

   initial begin
      logic [10:0] pools[NUM_PHASES];
      int p, n;
      pools = '{11'd2047, 11'd0, 11'd1, 11'd1024, 11'd0, 11'd2047};
      pools[4] = 11'($urandom);
      for (n = 0; n < ORDERS; n++) shadow_heads[n] = NIL;
      shadow_pool = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      for (p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct = (p < 2) ? 33 : (p < 4) ? 63 : 0;
         recv_idle_pct = (p < 2) ? 63 : (p < 4) ? 33 : 0;
         write_pool(pools[p]);
         queue_req(MODE_INIT, '0, '0);
         if (p == 0) begin
            // edge sizes, exhaustion, merges and odd buddies
            queue_req(MODE_TAKE, 24'd0, '0);
            queue_req(MODE_TAKE, 24'd1, 11'h7FF);
            queue_req(MODE_TAKE, 24'd4096, '0);
            queue_req(MODE_TAKE, 24'd4097, '0);
            queue_req(MODE_TAKE, 24'hFFFFFF, '0);
            queue_req(MODE_TAKE, 24'd4194304, '0);
            queue_req(MODE_TAKE, 24'd4194304, '0);
            queue_req(MODE_TAKE, 24'd4194305, '0);
            queue_req(MODE_GIVE, 24'hFFFFFF, 11'd5);
            queue_req(MODE_GIVE, 24'd4194304, 11'd0);
            queue_req(MODE_GIVE, 24'd0, 11'd2046);
            queue_req(MODE_GIVE, 24'd1, 11'd2047);
            queue_req(MODE_GIVE, 24'd8192, 11'd1024);
            queue_req(MODE_GIVE, 24'd0, 11'd1);
            queue_req(MODE_GIVE, 24'd0, 11'd1);
            queue_req(MODE_NONE, 24'hFFFFFF, 11'h7FF);
            queue_req(MODE_INIT, '0, '0);
            queue_req(MODE_GIVE, 24'd4096, 11'd0);
            queue_req(MODE_TAKE, 24'd2048, '0);
         end
         for (n = 0; n < PHASE_ITEMS; n++) random_word();
         wait_drained();
      end
      if (!failed) begin
         $display("[buddy_block_allocator] OK");
      end else begin
         $display("[buddy_block_allocator] ERROR");
      end
      $finish;
   end

endmodule
